/* hdl/kfts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kfts_pkg;

  localparam int ACC_W     = 50;
  localparam int PROD_W    = 48;
  localparam int PC_W      = 7;
  localparam int DIV_STEPS = 48;
  localparam int DIV_CNT_W = 6;

  localparam logic [PC_W-1:0]   PROG_LAST = 7'd80;
  localparam logic signed [31:0] Q_ONE    = 32'sh0001_0000;
  localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] accel;
    logic signed [31:0] gps_position;
  } kf_in_t;

  typedef struct packed {
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] innovation;
  } kf_out_t;

  typedef enum logic [2:0] {
    CFG_TRANS_ROW0  = 3'd0,
    CFG_TRANS_ROW1  = 3'd1,
    CFG_CTRL_GAIN   = 3'd2,
    CFG_PNOISE_ROW0 = 3'd3,
    CFG_PNOISE_ROW1 = 3'd4,
    CFG_OBS_ROW     = 3'd5,
    CFG_MEAS_NOISE  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DIV,
    S_DFIN,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LDP,
    ACC_ADDP,
    ACC_LDA,
    ACC_ADDA,
    ACC_SUBA
  } acc_op_t;

  // Operand / destination codes. Only the first group is writable.
  typedef enum logic [5:0] {
    R_X0, R_X1, R_P0, R_P1, R_P2, R_P3, R_XP0, R_XP1,
    R_T0, R_T1, R_T2, R_T3, R_PP0, R_PP1, R_PP2, R_PP3,
    R_Y, R_S, R_HT0, R_HT1, R_K0, R_K1, R_TMP,
    C_A00, C_A01, C_A10, C_A11, C_B0, C_B1,
    C_Q0, C_Q1, C_Q2, C_Q3, C_H0, C_H1,
    C_U, C_Z, C_R, C_ONE, C_ZERO
  } src_t;

  typedef struct packed {
    logic    mul;
    acc_op_t acc;
    logic    wr;
    logic    dv;
    src_t    sa;
    src_t    sb;
    src_t    dst;
  } uop_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (&v[ACC_W-1:31] || ~|v[ACC_W-1:31]) begin
      r = v[31:0];
    end else if (v[ACC_W-1]) begin
      r = S32_MIN;
    end else begin
      r = S32_MAX;
    end
    return r;
  endfunction

  function automatic uop_t uo(input int mul, input acc_op_t acc, input int wr,
                              input src_t sa, input src_t sb, input src_t dst);
    uop_t u;
    u.mul = (mul != 0);
    u.acc = acc;
    u.wr  = (wr != 0);
    u.dv  = 1'b0;
    u.sa  = sa;
    u.sb  = sb;
    u.dst = dst;
    return u;
  endfunction

  function automatic uop_t udiv(input src_t num, input src_t dst);
    uop_t u;
    u     = uo(0, ACC_NONE, 0, num, C_ZERO, dst);
    u.dv  = 1'b1;
    return u;
  endfunction

  // Microprogram. A mul issued at step n is consumed by an LDP/ADDP at a later
  // step; the product register only changes on steps that multiply.
  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      // predicted state
      7'd0:  u = uo(1, ACC_NONE, 0, C_A00, R_X0, C_ZERO);
      7'd1:  u = uo(1, ACC_LDP,  0, C_A01, R_X1, C_ZERO);
      7'd2:  u = uo(1, ACC_ADDP, 0, C_B0,  C_U,  C_ZERO);
      7'd3:  u = uo(1, ACC_ADDP, 1, C_A10, R_X0, R_XP0);
      7'd4:  u = uo(1, ACC_LDP,  0, C_A11, R_X1, C_ZERO);
      7'd5:  u = uo(1, ACC_ADDP, 0, C_B1,  C_U,  C_ZERO);
      // A P
      7'd6:  u = uo(1, ACC_ADDP, 1, C_A00, R_P0, R_XP1);
      7'd7:  u = uo(1, ACC_LDP,  0, C_A01, R_P2, C_ZERO);
      7'd8:  u = uo(1, ACC_ADDP, 1, C_A00, R_P1, R_T0);
      7'd9:  u = uo(1, ACC_LDP,  0, C_A01, R_P3, C_ZERO);
      7'd10: u = uo(1, ACC_ADDP, 1, C_A10, R_P0, R_T1);
      7'd11: u = uo(1, ACC_LDP,  0, C_A11, R_P2, C_ZERO);
      7'd12: u = uo(1, ACC_ADDP, 1, C_A10, R_P1, R_T2);
      7'd13: u = uo(1, ACC_LDP,  0, C_A11, R_P3, C_ZERO);
      // (A P) A^T
      7'd14: u = uo(1, ACC_ADDP, 1, R_T0,  C_A00, R_T3);
      7'd15: u = uo(1, ACC_LDP,  0, R_T1,  C_A01, C_ZERO);
      7'd16: u = uo(1, ACC_ADDP, 1, R_T0,  C_A10, R_PP0);
      7'd17: u = uo(1, ACC_LDP,  0, R_T1,  C_A11, C_ZERO);
      7'd18: u = uo(1, ACC_ADDP, 1, R_T2,  C_A00, R_PP1);
      7'd19: u = uo(1, ACC_LDP,  0, R_T3,  C_A01, C_ZERO);
      7'd20: u = uo(1, ACC_ADDP, 1, R_T2,  C_A10, R_PP2);
      7'd21: u = uo(1, ACC_LDP,  0, R_T3,  C_A11, C_ZERO);
      7'd22: u = uo(0, ACC_ADDP, 1, C_ZERO, C_ZERO, R_PP3);
      // + Q
      7'd23: u = uo(0, ACC_LDA,  0, R_PP0, C_ZERO, C_ZERO);
      7'd24: u = uo(0, ACC_ADDA, 1, C_Q0,  C_ZERO, R_PP0);
      7'd25: u = uo(0, ACC_LDA,  0, R_PP1, C_ZERO, C_ZERO);
      7'd26: u = uo(0, ACC_ADDA, 1, C_Q1,  C_ZERO, R_PP1);
      7'd27: u = uo(0, ACC_LDA,  0, R_PP2, C_ZERO, C_ZERO);
      7'd28: u = uo(0, ACC_ADDA, 1, C_Q2,  C_ZERO, R_PP2);
      7'd29: u = uo(0, ACC_LDA,  0, R_PP3, C_ZERO, C_ZERO);
      7'd30: u = uo(0, ACC_ADDA, 1, C_Q3,  C_ZERO, R_PP3);
      // innovation
      7'd31: u = uo(1, ACC_NONE, 0, C_H0,  R_XP0, C_ZERO);
      7'd32: u = uo(1, ACC_LDP,  0, C_H1,  R_XP1, C_ZERO);
      7'd33: u = uo(0, ACC_ADDP, 1, C_ZERO, C_ZERO, R_TMP);
      7'd34: u = uo(0, ACC_LDA,  0, C_Z,   C_ZERO, C_ZERO);
      7'd35: u = uo(0, ACC_SUBA, 1, R_TMP, C_ZERO, R_Y);
      // H P, then S
      7'd36: u = uo(1, ACC_NONE, 0, C_H0,  R_PP0, C_ZERO);
      7'd37: u = uo(1, ACC_LDP,  0, C_H1,  R_PP2, C_ZERO);
      7'd38: u = uo(1, ACC_ADDP, 1, C_H0,  R_PP1, R_T0);
      7'd39: u = uo(1, ACC_LDP,  0, C_H1,  R_PP3, C_ZERO);
      7'd40: u = uo(1, ACC_ADDP, 1, R_T0,  C_H0,  R_T1);
      7'd41: u = uo(1, ACC_LDP,  0, R_T1,  C_H1,  C_ZERO);
      7'd42: u = uo(1, ACC_ADDP, 1, R_PP0, C_H0,  R_S);
      7'd43: u = uo(0, ACC_LDA,  0, R_S,   C_ZERO, C_ZERO);
      7'd44: u = uo(0, ACC_ADDA, 1, C_R,   C_ZERO, R_S);
      // P H^T
      7'd45: u = uo(1, ACC_LDP,  0, R_PP1, C_H1,  C_ZERO);
      7'd46: u = uo(1, ACC_ADDP, 1, R_PP2, C_H0,  R_HT0);
      7'd47: u = uo(1, ACC_LDP,  0, R_PP3, C_H1,  C_ZERO);
      7'd48: u = uo(0, ACC_ADDP, 1, C_ZERO, C_ZERO, R_HT1);
      // gain
      7'd49: u = udiv(R_HT0, R_K0);
      7'd50: u = udiv(R_HT1, R_K1);
      // state update
      7'd51: u = uo(1, ACC_NONE, 0, R_K0,  R_Y,   C_ZERO);
      7'd52: u = uo(1, ACC_LDP,  1, R_K1,  R_Y,   R_TMP);
      7'd53: u = uo(0, ACC_LDA,  0, R_XP0, C_ZERO, C_ZERO);
      7'd54: u = uo(0, ACC_ADDA, 1, R_TMP, C_ZERO, R_X0);
      7'd55: u = uo(0, ACC_LDP,  1, C_ZERO, C_ZERO, R_TMP);
      7'd56: u = uo(0, ACC_LDA,  0, R_XP1, C_ZERO, C_ZERO);
      7'd57: u = uo(0, ACC_ADDA, 1, R_TMP, C_ZERO, R_X1);
      // I - K H
      7'd58: u = uo(1, ACC_NONE, 0, R_K0,  C_H0,  C_ZERO);
      7'd59: u = uo(1, ACC_LDP,  1, R_K0,  C_H1,  R_TMP);
      7'd60: u = uo(0, ACC_LDA,  0, C_ONE, C_ZERO, C_ZERO);
      7'd61: u = uo(0, ACC_SUBA, 1, R_TMP, C_ZERO, R_T0);
      7'd62: u = uo(0, ACC_LDP,  1, C_ZERO, C_ZERO, R_TMP);
      7'd63: u = uo(0, ACC_LDA,  0, C_ZERO, C_ZERO, C_ZERO);
      7'd64: u = uo(0, ACC_SUBA, 1, R_TMP, C_ZERO, R_T1);
      7'd65: u = uo(1, ACC_NONE, 0, R_K1,  C_H0,  C_ZERO);
      7'd66: u = uo(1, ACC_LDP,  1, R_K1,  C_H1,  R_TMP);
      7'd67: u = uo(0, ACC_LDA,  0, C_ZERO, C_ZERO, C_ZERO);
      7'd68: u = uo(0, ACC_SUBA, 1, R_TMP, C_ZERO, R_T2);
      7'd69: u = uo(0, ACC_LDP,  1, C_ZERO, C_ZERO, R_TMP);
      7'd70: u = uo(0, ACC_LDA,  0, C_ONE, C_ZERO, C_ZERO);
      7'd71: u = uo(0, ACC_SUBA, 1, R_TMP, C_ZERO, R_T3);
      // (I - K H) P
      7'd72: u = uo(1, ACC_NONE, 0, R_T0,  R_PP0, C_ZERO);
      7'd73: u = uo(1, ACC_LDP,  0, R_T1,  R_PP2, C_ZERO);
      7'd74: u = uo(1, ACC_ADDP, 1, R_T0,  R_PP1, R_P0);
      7'd75: u = uo(1, ACC_LDP,  0, R_T1,  R_PP3, C_ZERO);
      7'd76: u = uo(1, ACC_ADDP, 1, R_T2,  R_PP0, R_P1);
      7'd77: u = uo(1, ACC_LDP,  0, R_T3,  R_PP2, C_ZERO);
      7'd78: u = uo(1, ACC_ADDP, 1, R_T2,  R_PP1, R_P2);
      7'd79: u = uo(1, ACC_LDP,  0, R_T3,  R_PP3, C_ZERO);
      7'd80: u = uo(0, ACC_ADDP, 1, C_ZERO, C_ZERO, R_P3);
      default: u = uo(0, ACC_NONE, 0, C_ZERO, C_ZERO, C_ZERO);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* hdl/kalman_filter_two_state.sv */
`timescale 1ns / 1ps
`default_nettype none
// Two-state linear Kalman filter, signed Q16.16, saturating.
// Input channel (in_valid / in_stall / in_data): one beat carries an
// acceleration control value and a position measurement. in_stall is high
// whenever an update is in progress; one beat is taken at a time.
// Output channel (out_valid / out_stall / out_data): one beat per input beat,
// with the updated position, velocity and the measurement residual.
// Configuration (cfg_we / cfg_addr / cfg_wdata): write-only, one register per
// cycle; the user must write only while the filter is idle, which the block
// does not enforce. Unknown indexes are dropped. A microprogram of 81 steps
// drives one 32x32 multiplier and one 50-bit accumulator; each of the two
// gain divisions runs through a radix-2 restoring divider, between a start
// step and a writeback step.
// Reset: state vector to zero, covariance to identity, registers to their
// defaults (A = I, B = 0, Q = 0, H = [1 0], R = 1.0); both channels idle.
// Output stall: the result sits in the output register; a finished update
// waits for that register to empty (or be taken that cycle) before it is
// written, and a new input beat can be taken the cycle after the result
// enters the output register, even while it is still stalled there.
module kalman_filter_two_state (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire kfts_pkg::kf_in_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output kfts_pkg::kf_out_t   out_data,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_addr,
  input  wire  [63:0]         cfg_wdata
);
  import kfts_pkg::*;

  // configuration registers
  logic [63:0] trans_row0_r, trans_row1_r, ctrl_gain_r;
  logic [63:0] pnoise_row0_r, pnoise_row1_r, obs_row_r;
  logic [30:0] meas_noise_r;

  // filter state and scratch registers
  logic signed [31:0] x0_r, x1_r, p0_r, p1_r, p2_r, p3_r;
  logic signed [31:0] xp0_r, xp1_r, t0_r, t1_r, t2_r, t3_r;
  logic signed [31:0] pp0_r, pp1_r, pp2_r, pp3_r;
  logic signed [31:0] y_r, s_r, ht0_r, ht1_r, k0_r, k1_r, tmp_r;
  logic signed [31:0] u_r, z_r;

  // sequencer
  state_t            state_r, state_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  uop_t              uop;
  logic              ex_en, div_start, k_wr, out_load, in_take;

  // shared datapath
  logic signed [31:0]       opa, opb;
  logic signed [63:0]       prod_full;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, prod_ext, opa_ext;
  logic                     wr_en;
  src_t                     wr_dst;
  logic signed [31:0]       wr_val;

  // divider
  logic [32:0]          div_rem_r;
  logic [PROD_W-1:0]    div_q_r;
  logic [31:0]          div_dsr_r;
  logic                 div_neg_r, div_zero_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [32:0]          div_rem_sh;
  logic [33:0]          div_diff;
  logic signed [31:0]   div_res;

  logic               out_valid_r;
  kf_out_t            out_data_r;

  function automatic logic signed [31:0] rd(input src_t s);
    logic signed [31:0] v;
    case (s)
      R_X0:   v = x0_r;
      R_X1:   v = x1_r;
      R_P0:   v = p0_r;
      R_P1:   v = p1_r;
      R_P2:   v = p2_r;
      R_P3:   v = p3_r;
      R_XP0:  v = xp0_r;
      R_XP1:  v = xp1_r;
      R_T0:   v = t0_r;
      R_T1:   v = t1_r;
      R_T2:   v = t2_r;
      R_T3:   v = t3_r;
      R_PP0:  v = pp0_r;
      R_PP1:  v = pp1_r;
      R_PP2:  v = pp2_r;
      R_PP3:  v = pp3_r;
      R_Y:    v = y_r;
      R_S:    v = s_r;
      R_HT0:  v = ht0_r;
      R_HT1:  v = ht1_r;
      R_K0:   v = k0_r;
      R_K1:   v = k1_r;
      R_TMP:  v = tmp_r;
      C_A00:  v = trans_row0_r[63:32];
      C_A01:  v = trans_row0_r[31:0];
      C_A10:  v = trans_row1_r[63:32];
      C_A11:  v = trans_row1_r[31:0];
      C_B0:   v = ctrl_gain_r[63:32];
      C_B1:   v = ctrl_gain_r[31:0];
      C_Q0:   v = pnoise_row0_r[63:32];
      C_Q1:   v = pnoise_row0_r[31:0];
      C_Q2:   v = pnoise_row1_r[63:32];
      C_Q3:   v = pnoise_row1_r[31:0];
      C_H0:   v = obs_row_r[63:32];
      C_H1:   v = obs_row_r[31:0];
      C_U:    v = u_r;
      C_Z:    v = z_r;
      C_R:    v = {1'b0, meas_noise_r};
      C_ONE:  v = Q_ONE;
      default: v = '0;
    endcase
    return v;
  endfunction

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_row0_r  <= {Q_ONE, 32'h0};
      trans_row1_r  <= {32'h0, Q_ONE};
      ctrl_gain_r   <= '0;
      pnoise_row0_r <= '0;
      pnoise_row1_r <= '0;
      obs_row_r     <= {Q_ONE, 32'h0};
      meas_noise_r  <= Q_ONE[30:0];
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TRANS_ROW0:  trans_row0_r  <= cfg_wdata;
        CFG_TRANS_ROW1:  trans_row1_r  <= cfg_wdata;
        CFG_CTRL_GAIN:   ctrl_gain_r   <= cfg_wdata;
        CFG_PNOISE_ROW0: pnoise_row0_r <= cfg_wdata;
        CFG_PNOISE_ROW1: pnoise_row1_r <= cfg_wdata;
        CFG_OBS_ROW:     obs_row_r     <= cfg_wdata;
        CFG_MEAS_NOISE:  meas_noise_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign uop      = prog(pc_r);
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    in_take   = 1'b0;
    ex_en     = 1'b0;
    div_start = 1'b0;
    k_wr      = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_take   = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (uop.dv) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          ex_en = 1'b1;
          if (pc_r == PROG_LAST) begin
            state_nxt = S_FIN;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        k_wr      = 1'b1;
        pc_nxt    = pc_r + 1'b1;
        state_nxt = S_RUN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          pc_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      u_r <= in_data.accel;
      z_r <= in_data.gps_position;
    end
  end

  // ---------------- multiply / accumulate ----------------
  assign opa       = rd(uop.sa);
  assign opb       = rd(uop.sb);
  assign prod_full = opa * opb;
  assign prod_ext  = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign opa_ext   = {{(ACC_W-32){opa[31]}}, opa};

  always_comb begin
    case (uop.acc)
      ACC_LDP:  acc_nxt = prod_ext;
      ACC_ADDP: acc_nxt = acc_r + prod_ext;
      ACC_LDA:  acc_nxt = opa_ext;
      ACC_ADDA: acc_nxt = acc_r + opa_ext;
      ACC_SUBA: acc_nxt = acc_r - opa_ext;
      default:  acc_nxt = acc_r;
    endcase
  end

  // floor(a*b / 2^16) is the arithmetic shift: keep bits 63..16
  always_ff @(posedge clk) begin
    if (ex_en) begin
      acc_r <= acc_nxt;
      if (uop.mul) begin
        prod_r <= prod_full[63:16];
      end
    end
  end

  // ---------------- register writeback ----------------
  assign wr_en  = (ex_en && uop.wr) || k_wr;
  assign wr_dst = uop.dst;
  assign wr_val = k_wr ? div_res : sat32(acc_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r <= '0;
      x1_r <= '0;
      p0_r <= Q_ONE;
      p1_r <= '0;
      p2_r <= '0;
      p3_r <= Q_ONE;
    end else if (wr_en) begin
      case (wr_dst)
        R_X0: x0_r <= wr_val;
        R_X1: x1_r <= wr_val;
        R_P0: p0_r <= wr_val;
        R_P1: p1_r <= wr_val;
        R_P2: p2_r <= wr_val;
        R_P3: p3_r <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_dst)
        R_XP0: xp0_r <= wr_val;
        R_XP1: xp1_r <= wr_val;
        R_T0:  t0_r  <= wr_val;
        R_T1:  t1_r  <= wr_val;
        R_T2:  t2_r  <= wr_val;
        R_T3:  t3_r  <= wr_val;
        R_PP0: pp0_r <= wr_val;
        R_PP1: pp1_r <= wr_val;
        R_PP2: pp2_r <= wr_val;
        R_PP3: pp3_r <= wr_val;
        R_Y:   y_r   <= wr_val;
        R_S:   s_r   <= wr_val;
        R_HT0: ht0_r <= wr_val;
        R_HT1: ht1_r <= wr_val;
        R_K0:  k0_r  <= wr_val;
        R_K1:  k1_r  <= wr_val;
        R_TMP: tmp_r <= wr_val;
        default: ;
      endcase
    end
  end

  // ---------------- gain divider: (pht << 16) / S, truncating ----------------
  assign div_rem_sh = {div_rem_r[31:0], div_q_r[PROD_W-1]};
  assign div_diff   = {1'b0, div_rem_sh} - {2'b0, div_dsr_r};

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_q_r    <= {(opa[31] ? -opa : opa), 16'h0};
      div_rem_r  <= '0;
      div_dsr_r  <= s_r[31] ? -s_r : s_r;
      div_neg_r  <= opa[31] ^ s_r[31];
      div_zero_r <= (s_r == '0);
      div_cnt_r  <= '0;
    end else if (state_r == S_DIV) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (!div_diff[33]) begin
        div_rem_r <= div_diff[32:0];
        div_q_r   <= {div_q_r[PROD_W-2:0], 1'b1};
      end else begin
        div_rem_r <= div_rem_sh;
        div_q_r   <= {div_q_r[PROD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (div_zero_r) begin
      div_res = '0;
    end else if (div_neg_r) begin
      div_res = (div_q_r > PROD_W'(48'h8000_0000)) ? S32_MIN : -div_q_r[31:0];
    end else begin
      div_res = (div_q_r > PROD_W'(48'h7FFF_FFFF)) ? S32_MAX : div_q_r[31:0];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && out_stall) || out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.est_position <= x0_r;
      out_data_r.est_velocity <= x1_r;
      out_data_r.innovation   <= y_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RUN && pc_r == '0))
    else $error("accepted beat did not start the microprogram");

  a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pc_r == '0))
    else $error("sequencer idle with nonzero step");

  a_dfin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DFIN) |-> ($past(state_r) == S_DIV && uop.dv))
    else $error("gain writeback without a division");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid || !out_stall)) |=> (out_valid && state_r == S_IDLE))
    else $error("finished update not handed to output");

endmodule

`default_nettype wire

/* tb/tb_kalman_filter_two_state.sv */
`timescale 1ns / 1ps

// Scoreboard: shadow copy of the filter state and registers, a predictor of
// one update, and a queue of the estimates still owed by the block.
class kf_scoreboard;
  logic [63:0] regs [7];
  logic signed [31:0] xv [2];
  logic signed [31:0] pm [4];
  kfts_pkg::kf_out_t pending_est [$];
  int errors;

  function new();
    regs[0] = 64'h0001_0000_0000_0000;
    regs[1] = 64'h0000_0000_0001_0000;
    regs[2] = '0;
    regs[3] = '0;
    regs[4] = '0;
    regs[5] = 64'h0001_0000_0000_0000;
    regs[6] = 64'h0000_0000_0001_0000;
    xv[0] = 0; xv[1] = 0;
    pm[0] = 32'sh10000; pm[1] = 0; pm[2] = 0; pm[3] = 32'sh10000;
    errors = 0;
  endfunction

  function void write_reg(kfts_pkg::cfg_idx_t idx, logic [63:0] v);
    if (idx == kfts_pkg::CFG_MEAS_NOISE) regs[idx] = {33'd0, v[30:0]};
    else regs[idx] = v;
  endfunction

  // Q16.16 product, floor of the shift (arithmetic shift does that).
  function automatic longint qm(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void mm(input logic signed [31:0] l [4],
                             input logic signed [31:0] r [4],
                             output logic signed [31:0] o [4]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        o[i*2+j] = clamp(qm(l[i*2], r[j]) + qm(l[i*2+1], r[2+j]));
  endfunction

  function void note_input(kfts_pkg::kf_in_t d);
    logic signed [31:0] a [4], at [4], q [4], ap [4], pp [4], m [4], pn [4];
    logic signed [31:0] h0, h1, b0, b1, x0, x1, hx, y, s, hp0, hp1, ph0, ph1, k0, k1;
    kfts_pkg::kf_out_t e;
    a[0] = regs[0][63:32]; a[1] = regs[0][31:0];
    a[2] = regs[1][63:32]; a[3] = regs[1][31:0];
    at[0] = a[0]; at[1] = a[2]; at[2] = a[1]; at[3] = a[3];
    q[0] = regs[3][63:32]; q[1] = regs[3][31:0];
    q[2] = regs[4][63:32]; q[3] = regs[4][31:0];
    b0 = regs[2][63:32]; b1 = regs[2][31:0];
    h0 = regs[5][63:32]; h1 = regs[5][31:0];
    x0 = clamp(qm(a[0], xv[0]) + qm(a[1], xv[1]) + qm(b0, d.accel));
    x1 = clamp(qm(a[2], xv[0]) + qm(a[3], xv[1]) + qm(b1, d.accel));
    mm(a, pm, ap);
    mm(ap, at, pp);
    for (int i = 0; i < 4; i++) pp[i] = clamp(longint'(pp[i]) + longint'(q[i]));
    hx = clamp(qm(h0, x0) + qm(h1, x1));
    y = clamp(longint'(d.gps_position) - longint'(hx));
    hp0 = clamp(qm(h0, pp[0]) + qm(h1, pp[2]));
    hp1 = clamp(qm(h0, pp[1]) + qm(h1, pp[3]));
    s = clamp(qm(hp0, h0) + qm(hp1, h1));
    s = clamp(longint'(s) + longint'(regs[6][30:0]));
    ph0 = clamp(qm(pp[0], h0) + qm(pp[1], h1));
    ph1 = clamp(qm(pp[2], h0) + qm(pp[3], h1));
    if (s == 0) begin
      k0 = 0; k1 = 0;
    end else begin
      k0 = clamp((longint'(ph0) * 65536) / longint'(s));
      k1 = clamp((longint'(ph1) * 65536) / longint'(s));
    end
    x0 = clamp(longint'(x0) + longint'(clamp(qm(k0, y))));
    x1 = clamp(longint'(x1) + longint'(clamp(qm(k1, y))));
    m[0] = clamp(65536 - longint'(clamp(qm(k0, h0))));
    m[1] = clamp(-longint'(clamp(qm(k0, h1))));
    m[2] = clamp(-longint'(clamp(qm(k1, h0))));
    m[3] = clamp(65536 - longint'(clamp(qm(k1, h1))));
    mm(m, pp, pn);
    xv[0] = x0; xv[1] = x1;
    pm = pn;
    e.est_position = x0; e.est_velocity = x1; e.innovation = y;
    pending_est.push_back(e);
  endfunction

  function void check_result(kfts_pkg::kf_out_t got);
    kfts_pkg::kf_out_t e;
    if (pending_est.size() == 0) begin
      $display("%0t unexpected result: got %h", $realtime, got);
      errors++;
      return;
    end
    e = pending_est.pop_front();
    if (got.est_position !== e.est_position) begin
      $display("%0t est_position: exp %h act %h", $realtime, e.est_position, got.est_position);
      errors++;
    end
    if (got.est_velocity !== e.est_velocity) begin
      $display("%0t est_velocity: exp %h act %h", $realtime, e.est_velocity, got.est_velocity);
      errors++;
    end
    if (got.innovation !== e.innovation) begin
      $display("%0t innovation: exp %h act %h", $realtime, e.innovation, got.innovation);
      errors++;
    end
  endfunction
endclass

module tb_kalman_filter_two_state;
  import kfts_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int UPDATE_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kf_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kf_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;

  // idling percentages, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;     // long receiver hold-off requested by stimulus
  longint cycle_count = 0;
  kf_scoreboard estimates;

  always #4 clk = ~clk;

  kalman_filter_two_state dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Result side: check every accepted beat at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) estimates.check_result(out_data);
  end

  // Receiver stall pattern, driven on the falling edge.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("kalman_filter_two_state regression: fail");
      $finish;
    end
  end

  // Q16.16 test values: mostly moderate, sometimes extreme.
  function automatic logic [31:0] pick_val();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // Offer one beat; held stable until accepted. Driven with blocking writes
  // so back-to-back beats can drop and raise valid at the same falling edge.
  task automatic send_beat(input logic [31:0] u, input logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data.accel = u;
    in_data.gps_position = z;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    estimates.note_input(in_data);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (estimates.pending_est.size() != 0) @(negedge clk);
    repeat (UPDATE_CYCLES) @(negedge clk);
  endtask

  // Register write while idle; the scoreboard copy follows.
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] v);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    estimates.write_reg(idx, v);
  endtask

  // A stable setting: near-identity transition with time step, small noises.
  task automatic tame_setting();
    write_reg(CFG_TRANS_ROW0, {32'h0001_0000, 32'(($urandom_range(3) + 1) << 12)});
    write_reg(CFG_TRANS_ROW1, {32'h0, 32'h0001_0000});
    write_reg(CFG_CTRL_GAIN, {32'($urandom_range(16'h1000)), 32'($urandom_range(16'h2000))});
    write_reg(CFG_PNOISE_ROW0, {32'($urandom_range(16'h800)), 32'h0});
    write_reg(CFG_PNOISE_ROW1, {32'h0, 32'($urandom_range(16'h800))});
    write_reg(CFG_OBS_ROW, {32'h0001_0000, 32'h0});
    write_reg(CFG_MEAS_NOISE, 64'($urandom_range(32'h0004_0000, 32'h0000_1000)));
  endtask

  task automatic wild_setting();
    for (int i = 0; i <= int'(CFG_MEAS_NOISE); i++)
      write_reg(cfg_idx_t'(i), {pick_val(), pick_val()});
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_beat(pick_val(), pick_val());
  endtask

  initial begin
    estimates = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default registers, field extremes.
    send_beat(32'h0, 32'h0);
    send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(32'h8000_0000, 32'h8000_0000);
    send_beat(32'hFFFF_FFFF, 32'h0001_0000);
    send_beat(32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    // Zero innovation variance: H = 0 and R = 0 give S = 0, gain zero.
    write_reg(CFG_OBS_ROW, 64'h0);
    write_reg(CFG_MEAS_NOISE, 64'h0);
    send_beat(32'h0001_0000, 32'h0002_0000);
    send_beat(32'hFFFF_0000, 32'h8000_0000);
    drain();
    // Negative innovation variance: large negative Q and R = 0.
    write_reg(CFG_OBS_ROW, 64'h0001_0000_0000_0000);
    write_reg(CFG_PNOISE_ROW0, 64'hFFF0_0000_0000_0000);
    send_beat(32'h0, 32'h0003_0000);
    send_beat(32'h0, 32'hFFFD_0000);
    drain();
    // Extremes of five registers, and an index beyond the list.
    write_reg(CFG_TRANS_ROW0, 64'h7FFF_FFFF_8000_0000);
    write_reg(CFG_TRANS_ROW1, 64'h8000_0000_7FFF_FFFF);
    write_reg(CFG_CTRL_GAIN, 64'h7FFF_FFFF_8000_0000);
    write_reg(CFG_PNOISE_ROW1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_MEAS_NOISE, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_we = 1'b1; cfg_addr = 3'd7; cfg_wdata = '1;
    @(negedge clk);
    cfg_we = 1'b0;
    send_beat(32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(32'h0, 32'h0);
    drain();

    // Phase 1: sender idles lightly, receiver heavily.
    send_idle_pct = 15; recv_idle_pct = 48;
    tame_setting();
    run_random(300);
    drain();
    wild_setting();
    run_random(150);
    drain();
    // Long receiver hold-off while beats keep coming: input must stall.
    tame_setting();
    hold_cycles = 2000;
    run_random(30);
    drain();

    // Phase 2: roles swapped.
    send_idle_pct = 48; recv_idle_pct = 15;
    tame_setting();
    run_random(300);
    drain();
    wild_setting();
    run_random(150);
    drain();

    // Phase 3: no idling at all.
    send_idle_pct = 0; recv_idle_pct = 0;
    tame_setting();
    run_random(450);
    drain();
    wild_setting();
    run_random(200);
    drain();
    write_reg(CFG_TRANS_ROW0, 64'h0001_0000_0000_0000);
    write_reg(CFG_TRANS_ROW1, 64'h0000_0000_0001_0000);
    write_reg(CFG_OBS_ROW, 64'h0001_0000_0000_0000);
    write_reg(CFG_MEAS_NOISE, 64'h7FFF_FFFF);
    run_random(250);
    drain();

    if (estimates.errors == 0 && estimates.pending_est.size() == 0) begin
      $display("kalman_filter_two_state regression: pass");
    end else begin
      $display("kalman_filter_two_state regression: fail");
    end
    $finish;
  end
endmodule
